### src/mfmd_pkg.sv
// Shared types, constants and register codes for the multi-turn feedback decoder.
`timescale 1ns / 1ps

package mfmd_pkg;

    // Default encoder counts for one mechanical turn
    localparam int CPT_DEFAULT = 8192;

    // Depth of the queue between the frame filter and the turn tracker
    localparam int QUEUE_DEPTH = 4;

    // Configuration port widths
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Stream widths
    localparam int IN_DATA_W  = 88;
    localparam int IN_USER_W  = 11;
    localparam int OUT_DATA_W = 136;

    // Field widths
    localparam int ID_W    = 11;
    localparam int TIME_W  = 32;
    localparam int WORD_W  = 16;
    localparam int TEMP_W  = 8;
    localparam int TURN_W  = 32;
    localparam int POS_W   = 46;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FEEDBACK_ID  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_INTERVAL = 2'd1;

    // Register reset values
    localparam logic [ID_W-1:0]   FEEDBACK_ID_RST  = 11'd513;
    localparam logic [WORD_W-1:0] MIN_INTERVAL_RST = 16'd500;

    // Unpacked frame that passed the filter
    typedef struct packed {
        logic [TEMP_W-1:0]        temperature;
        logic signed [WORD_W-1:0] torque_current;
        logic signed [WORD_W-1:0] speed_rpm;
        logic [WORD_W-1:0]        encoder_angle;
    } frame_t;

    // Queue status seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } queue_stat_t;

endpackage

### src/motor_feedback_multiturn_decoder_top.sv
// Top level of the multi-turn motor feedback decoder.
`timescale 1ns / 1ps
// A frame accepted at the input is stored in the queue, then passes the stage-one
// register and the output register. One frame per cycle: the filter takes a frame whenever
// the four-entry queue has room, the tracker drains one entry per cycle unless the output stalls.
// Reset (rst_n low, async): turn count, stored angle, last timestamp and
// queue clear; feedback_id returns to 513 and min_interval_us to 500.

module motor_feedback_multiturn_decoder_top #(
    parameter int COUNTS_PER_TURN = mfmd_pkg::CPT_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // Configuration writes
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [mfmd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mfmd_pkg::CFG_DATA_W-1:0] cfg_data,
    // Received frames
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // time_us[31:0], byte0..byte6 [39:32]..[87:80]
    input  logic [mfmd_pkg::IN_DATA_W-1:0]  s_tdata,
    // frame_id[10:0]
    input  logic [mfmd_pkg::IN_USER_W-1:0]  s_tuser,
    // Decoded results
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // encoder_angle[15:0], speed_rpm[31:16], torque_current[47:32],
    // temperature[55:48], turn_count[87:56], total_position[133:88], zero pad
    output logic [mfmd_pkg::OUT_DATA_W-1:0] m_tdata
);
    import mfmd_pkg::*;

    queue_stat_t stat;
    frame_t      push_frame;
    frame_t      pop_frame;
    logic        push;
    logic        pop;

    assign cfg_ready = 1'b1;
    assign s_tready  = !stat.full;

    mfmd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr     (cfg_valid && cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_take    (s_tvalid && s_tready),
        .in_user    (s_tuser),
        .in_data    (s_tdata),
        .push       (push),
        .push_frame (push_frame)
    );

    mfmd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_frame (push_frame),
        .pop        (pop),
        .pop_frame  (pop_frame),
        .stat       (stat)
    );

    mfmd_back #(
        .COUNTS_PER_TURN (COUNTS_PER_TURN)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_frame (pop_frame),
        .stat      (stat),
        .pop       (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

### src/mfmd_front.sv
// Frame filter: identifier match, rate limit and big-endian unpacking.
`timescale 1ns / 1ps

module mfmd_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr,
    input  logic [mfmd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mfmd_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                          in_take,
    input  logic [mfmd_pkg::IN_USER_W-1:0]  in_user,
    input  logic [mfmd_pkg::IN_DATA_W-1:0]  in_data,
    output logic                          push,
    output mfmd_pkg::frame_t              push_frame
);
    import mfmd_pkg::*;

    logic [ID_W-1:0]   feedback_id_reg;
    logic [WORD_W-1:0] min_interval_reg;
    logic [TIME_W-1:0] last_time_reg;
    logic [TIME_W-1:0] time_us;
    logic [TIME_W-1:0] elapsed;
    logic              id_ok;
    logic              gap_ok;

    assign time_us = in_data[TIME_W-1:0];
    assign elapsed = time_us - last_time_reg;
    assign id_ok   = (in_user == feedback_id_reg);
    assign gap_ok  = (elapsed >= {{(TIME_W-WORD_W){1'b0}}, min_interval_reg});
    assign push    = in_take && id_ok && gap_ok;

    // Payload bytes follow the timestamp; angle, speed and torque are high byte first
    assign push_frame.encoder_angle  = {in_data[39:32], in_data[47:40]};
    assign push_frame.speed_rpm      = {in_data[55:48], in_data[63:56]};
    assign push_frame.torque_current = {in_data[71:64], in_data[79:72]};
    assign push_frame.temperature    = in_data[87:80];

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            feedback_id_reg  <= FEEDBACK_ID_RST;
            min_interval_reg <= MIN_INTERVAL_RST;
        end
        else if (cfg_wr)
        begin
            case (cfg_index)
                REG_FEEDBACK_ID:  feedback_id_reg  <= cfg_data[ID_W-1:0];
                REG_MIN_INTERVAL: min_interval_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Timestamp of the last frame let through
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            last_time_reg <= '0;
        else if (push)
            last_time_reg <= time_us;
    end

endmodule

### src/mfmd_queue.sv
// Short queue of filtered frames between the filter and the turn tracker.
`timescale 1ns / 1ps

module mfmd_queue #(
    parameter int DEPTH = mfmd_pkg::QUEUE_DEPTH
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  mfmd_pkg::frame_t      push_frame,
    input  logic                  pop,
    output mfmd_pkg::frame_t      pop_frame,
    output mfmd_pkg::queue_stat_t stat
);
    import mfmd_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    frame_t            slot_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              do_push;
    logic              do_pop;

    assign stat.full  = (count_reg == FULL_CNT);
    assign stat.empty = (count_reg == '0);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign pop_frame  = slot_reg[rd_ptr_reg];

    // Storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_frame;
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

### src/mfmd_back.sv
// Turn tracker and position stage with the registered result output.
`timescale 1ns / 1ps

module mfmd_back #(
    parameter int COUNTS_PER_TURN = mfmd_pkg::CPT_DEFAULT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  mfmd_pkg::frame_t               pop_frame,
    input  mfmd_pkg::queue_stat_t          stat,
    output logic                           pop,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [mfmd_pkg::OUT_DATA_W-1:0] m_tdata
);
    import mfmd_pkg::*;

    localparam int PROD_W = TURN_W + 18;
    localparam logic signed [17:0]       HALF_TURN = 18'(COUNTS_PER_TURN / 2);
    localparam logic signed [PROD_W-1:0] CPT_WIDE  = PROD_W'(COUNTS_PER_TURN);
    localparam logic signed [TURN_W-1:0] TURN_MAX  = {1'b0, {(TURN_W-1){1'b1}}};
    localparam logic signed [TURN_W-1:0] TURN_MIN  = {1'b1, {(TURN_W-1){1'b0}}};

    // Turn state
    logic [WORD_W-1:0]        prev_angle_reg;
    logic signed [TURN_W-1:0] turns_reg;
    logic signed [TURN_W-1:0] turns_next;
    logic                     seen_first_reg;

    // Stage one: frame plus updated turn count
    logic                     s1_valid_reg;
    frame_t                   s1_frame_reg;
    logic signed [TURN_W-1:0] s1_turns_reg;

    // Output register
    logic                     out_valid_reg;
    frame_t                   out_frame_reg;
    logic signed [TURN_W-1:0] out_turns_reg;
    logic [POS_W-1:0]         out_pos_reg;

    logic                     s2_load;
    logic                     s1_ready;
    logic [WORD_W-1:0]        delta;
    logic signed [17:0]       delta_wide;
    logic signed [PROD_W-1:0] prod;
    logic [POS_W-1:0]         pos_next;

    assign s2_load  = s1_valid_reg && (!out_valid_reg || m_tready);
    assign s1_ready = !s1_valid_reg || s2_load;
    assign pop      = s1_ready && !stat.empty;

    // Signed angle jump since the previous frame
    assign delta      = pop_frame.encoder_angle - prev_angle_reg;
    assign delta_wide = {{2{delta[WORD_W-1]}}, delta};

    // Turn step with saturation; the first frame makes no step
    always_comb
    begin
        turns_next = turns_reg;
        if (seen_first_reg)
        begin
            if (delta_wide > HALF_TURN)
            begin
                if (turns_reg != TURN_MIN)
                    turns_next = turns_reg - 1'b1;
            end
            else if (delta_wide < -HALF_TURN)
            begin
                if (turns_reg != TURN_MAX)
                    turns_next = turns_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_angle_reg <= '0;
            turns_reg      <= '0;
            seen_first_reg <= 1'b0;
        end
        else if (pop)
        begin
            prev_angle_reg <= pop_frame.encoder_angle;
            turns_reg      <= turns_next;
            seen_first_reg <= 1'b1;
        end
    end

    // Stage one register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (s1_ready)
            s1_valid_reg <= pop;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            s1_frame_reg <= pop_frame;
            s1_turns_reg <= turns_next;
        end
    end

    // Position = angle + counts per turn * turns, low bits kept
    assign prod     = {{(PROD_W-TURN_W){s1_turns_reg[TURN_W-1]}}, s1_turns_reg} * CPT_WIDE;
    assign pos_next = prod[POS_W-1:0] +
                      {{(POS_W-WORD_W){1'b0}}, s1_frame_reg.encoder_angle};

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s2_load)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s2_load)
        begin
            out_frame_reg <= s1_frame_reg;
            out_turns_reg <= s1_turns_reg;
            out_pos_reg   <= pos_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_pos_reg, out_turns_reg, out_frame_reg.temperature,
                       out_frame_reg.torque_current, out_frame_reg.speed_rpm,
                       out_frame_reg.encoder_angle};

endmodule

### src/mfmd_checker.sv
// Port-level checks on the decoder results, bound to the top level.
`timescale 1ns / 1ps

module mfmd_checker #(
    parameter int COUNTS_PER_TURN = mfmd_pkg::CPT_DEFAULT
) (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [mfmd_pkg::OUT_DATA_W-1:0] m_tdata
);
    import mfmd_pkg::*;

    localparam logic signed [63:0] CPT_WIDE = 64'(COUNTS_PER_TURN);

    logic                     out_take;
    logic [WORD_W-1:0]        angle;
    logic signed [TURN_W-1:0] turns;
    logic [POS_W-1:0]         pos;
    logic signed [63:0]       exp_pos;
    logic                     have_prev_reg;
    logic signed [TURN_W-1:0] prev_turns_reg;
    logic signed [TURN_W:0]   turn_step;

    assign out_take  = m_tvalid && m_tready;
    assign angle     = m_tdata[15:0];
    assign turns     = m_tdata[87:56];
    assign pos       = m_tdata[133:88];
    assign exp_pos   = 64'(turns) * CPT_WIDE + {48'b0, angle};
    assign turn_step = {turns[TURN_W-1], turns} - {prev_turns_reg[TURN_W-1], prev_turns_reg};

    // Track the turn count of the last delivered result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_prev_reg  <= 1'b0;
            prev_turns_reg <= '0;
        end
        else if (out_take)
        begin
            have_prev_reg  <= 1'b1;
            prev_turns_reg <= turns;
        end
    end

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // Position agrees with angle and turn count
    a_pos_match: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> pos == exp_pos[POS_W-1:0])
        else $error("total_position inconsistent with angle and turns");

    // First result after reset carries no turns
    a_first_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_take && !have_prev_reg |-> turns == '0)
        else $error("first result has nonzero turn count");

    // Turn count moves by at most one between results
    a_turn_step: assert property (@(posedge clk) disable iff (!rst_n)
        out_take && have_prev_reg |-> turn_step == '0 || turn_step == 1 || turn_step == -1)
        else $error("turn count jumped by more than one");

endmodule

bind motor_feedback_multiturn_decoder_top mfmd_checker #(
    .COUNTS_PER_TURN (COUNTS_PER_TURN)
) u_mfmd_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

### tb/sv/mfmd_feedback_checker.sv
// Monitor, predictor and scoreboard for the multi-turn feedback decoder streams.
`timescale 1ns / 1ps

module mfmd_feedback_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [mfmd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mfmd_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [mfmd_pkg::IN_DATA_W-1:0]  s_tdata,
    input  logic [mfmd_pkg::IN_USER_W-1:0]  s_tuser,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [mfmd_pkg::OUT_DATA_W-1:0] m_tdata,
    output int                              mismatches,
    output int                              outstanding
);
    import mfmd_pkg::*;

    localparam int HALF_TURN = CPT_DEFAULT / 2;
    localparam logic signed [TURN_W-1:0] TURN_MIN = 32'sh8000_0000;
    localparam logic signed [TURN_W-1:0] TURN_MAX = 32'sh7FFF_FFFF;

    // Decoded result, laid out as on m_tdata
    typedef struct packed {
        logic [POS_W-1:0]         total_position;
        logic signed [TURN_W-1:0] turn_count;
        frame_t                   frame;
    } decoded_t;

    // Predictor copy of the registers and tracker state
    logic [ID_W-1:0]          fb_id;
    logic [WORD_W-1:0]        min_gap;
    logic [WORD_W-1:0]        prev_angle;
    logic signed [TURN_W-1:0] turn_acc;
    bit                       angle_valid;
    logic [TIME_W-1:0]        last_stamp;

    decoded_t pending_results[$];
    int       fail_count = 0;
    int       queued_count = 0;

    assign mismatches  = fail_count;
    assign outstanding = queued_count;

    // Filter one frame; on accept, update turn state and build the result
    function automatic bit decode_frame(input logic [ID_W-1:0] id,
                                        input logic [IN_DATA_W-1:0] data,
                                        output decoded_t res);
        logic [TIME_W-1:0]        stamp;
        logic [TIME_W-1:0]        elapsed;
        logic [TIME_W-1:0]        gap;
        logic signed [WORD_W-1:0] jump;
        longint                   pos;
        stamp   = data[31:0];
        elapsed = stamp - last_stamp;
        gap     = {16'd0, min_gap};
        res     = '0;
        if (id != fb_id || elapsed < gap)
            return 1'b0;
        res.frame.encoder_angle  = {data[39:32], data[47:40]};
        res.frame.speed_rpm      = {data[55:48], data[63:56]};
        res.frame.torque_current = {data[71:64], data[79:72]};
        res.frame.temperature    = data[87:80];
        // jump wraps in 16 bits; the first frame only seeds the angle
        if (angle_valid)
        begin
            jump = res.frame.encoder_angle - prev_angle;
            if (int'(jump) > HALF_TURN)
            begin
                if (turn_acc != TURN_MIN)
                    turn_acc = turn_acc - 1;
            end
            else if (int'(jump) < -HALF_TURN)
            begin
                if (turn_acc != TURN_MAX)
                    turn_acc = turn_acc + 1;
            end
        end
        prev_angle  = res.frame.encoder_angle;
        angle_valid = 1'b1;
        last_stamp  = stamp;
        pos = longint'(res.frame.encoder_angle) + longint'(CPT_DEFAULT) * longint'(turn_acc);
        res.turn_count     = turn_acc;
        res.total_position = pos[POS_W-1:0];
        return 1'b1;
    endfunction

    function automatic void compare_field(input string field, input logic [63:0] want_v,
                                          input logic [63:0] got_v);
        if (want_v !== got_v)
        begin
            fail_count++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want_v, got_v);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        decoded_t want;
        decoded_t got;
        if (!rst_n)
        begin
            fb_id       = FEEDBACK_ID_RST;
            min_gap     = MIN_INTERVAL_RST;
            prev_angle  = '0;
            turn_acc    = '0;
            angle_valid = 1'b0;
            last_stamp  = '0;
            pending_results.delete();
            queued_count = 0;
        end
        else
        begin
            // register writes
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_FEEDBACK_ID)
                    fb_id = cfg_data[ID_W-1:0];
                else if (cfg_index == REG_MIN_INTERVAL)
                    min_gap = cfg_data;
            end
            // results against the oldest prediction
            if (m_tvalid && m_tready)
            begin
                got = m_tdata[$bits(decoded_t)-1:0];
                if (pending_results.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: result mismatch, expected none, actual %0h", $time, got);
                end
                else
                begin
                    want = pending_results.pop_front();
                    compare_field("encoder_angle", 64'(want.frame.encoder_angle),
                                  64'(got.frame.encoder_angle));
                    compare_field("speed_rpm", 64'(want.frame.speed_rpm),
                                  64'(got.frame.speed_rpm));
                    compare_field("torque_current", 64'(want.frame.torque_current),
                                  64'(got.frame.torque_current));
                    compare_field("temperature", 64'(want.frame.temperature),
                                  64'(got.frame.temperature));
                    compare_field("turn_count", 64'(want.turn_count), 64'(got.turn_count));
                    compare_field("total_position", 64'(want.total_position),
                                  64'(got.total_position));
                end
            end
            // frame requests
            if (s_tvalid && s_tready)
            begin
                if (decode_frame(s_tuser, s_tdata, want))
                    pending_results.push_back(want);
            end
            queued_count = pending_results.size();
        end
    end

endmodule

### tb/sv/tb_motor_feedback_multiturn_decoder_top.sv
// Stimulus, handshake pacing and verdict for the multi-turn feedback decoder.
`timescale 1ns / 1ps

module tb_motor_feedback_multiturn_decoder_top;
    import mfmd_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int LONG_HOLD      = 300;
    localparam int DRAIN_CYCLES   = 8;
    localparam int PHASE_ITEMS    = 190;
    localparam int RANDOM_PHASES  = 8;

    // Unused register slots, written once to show they change nothing
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic [IN_USER_W-1:0]  s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;

    int mismatches;
    int outstanding;
    int idle_cycles = 0;

    // Pacing controls shared with the ready process and the frame sender
    bit gaps_on  = 1'b1;
    bit stall_on = 1'b1;
    bit hold_out = 1'b0;

    // Sender-side view of the current setup and frame sequence
    logic [ID_W-1:0]   cur_id = FEEDBACK_ID_RST;
    logic [WORD_W-1:0] cur_gap = MIN_INTERVAL_RST;
    logic [TIME_W-1:0] stamp_us = '0;
    int                walk_angle = 0;

    always #4 clk = ~clk;

    motor_feedback_multiturn_decoder_top #(
        .COUNTS_PER_TURN(CPT_DEFAULT)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    mfmd_feedback_checker i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .mismatches (mismatches),
        .outstanding(outstanding)
    );

    // Result side: random stall bursts, one long hold-off on request
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_out)
            begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                hold_out = 1'b0;
            end
            else if (stall_on && $urandom_range(0, 5) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge clk);
            end
            else
                m_tready <= 1'b1;
        end
    end

    // Watchdog on cycles with no accepted request anywhere
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("[motor_feedback_multiturn_decoder_top] ERROR");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // Leaves cfg_valid high; the caller lowers it after the last write
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    task automatic set_config(input logic [ID_W-1:0] id, input logic [WORD_W-1:0] gap);
        logic [31:0] rnd;
        rnd = $urandom;
        // junk above the 11-bit identifier must be ignored
        write_reg(REG_FEEDBACK_ID, {rnd[4:0], id});
        write_reg(REG_MIN_INTERVAL, gap);
        cfg_valid <= 1'b0;
        cur_id  = id;
        cur_gap = gap;
    endtask

    // Stop offering, let every result out, then give dropped frames time to clear
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic send_frame(input logic [ID_W-1:0] id, input logic [TIME_W-1:0] stamp,
                              input logic [15:0] angle, input logic [15:0] speed,
                              input logic [15:0] torque, input logic [7:0] temp);
        if (gaps_on && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= id;
        s_tdata  <= {temp, torque[7:0], torque[15:8], speed[7:0], speed[15:8],
                     angle[7:0], angle[15:8], stamp};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // Mostly a plausible rotating encoder on the configured id, some noise
    task automatic random_frame(output logic [ID_W-1:0] id);
        int          pick;
        int          a;
        logic [31:0] rnd;
        logic [31:0] pay;
        logic [31:0] delta;
        logic [15:0] angle;
        rnd = $urandom;
        pay = $urandom;
        if ($urandom_range(0, 99) < 10)
            id = rnd[10:0];
        else
            id = cur_id;
        // timestamp step: mostly legal, some too early, some anywhere
        pick = $urandom_range(0, 99);
        if (pick < 70)
            delta = cur_gap + $urandom_range(0, 1000);
        else if (pick < 80)
            delta = {16'd0, cur_gap};
        else if (pick < 92)
            delta = (cur_gap == 0) ? 32'd0 : $urandom_range(0, cur_gap - 1);
        else
            delta = $urandom;
        stamp_us = stamp_us + delta;
        // angle: small moves, moves near half a turn, jumps, raw 16-bit values
        pick = $urandom_range(0, 99);
        if (pick < 70)
            a = walk_angle + int'($urandom_range(0, 6000)) - 3000;
        else if (pick < 80)
            a = walk_angle + (($urandom_range(0, 1) == 1) ? 4096 : -4096)
                + int'($urandom_range(0, 2)) - 1;
        else
            a = int'($urandom_range(0, 8191));
        a = ((a % 8192) + 8192) % 8192;
        if (pick < 95)
            angle = a[15:0];
        else
            angle = rnd[31:16];
        walk_angle = int'(angle) % 8192;
        send_frame(id, stamp_us, angle, pay[15:0], pay[31:16], rnd[23:16]);
    endtask

    initial
    begin
        int              ph;
        int              sent;
        logic [ID_W-1:0] used_id;
        logic [31:0]     rnd;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset setup: first-frame timing, id filter, turn thresholds, wrap
        send_frame(11'd513, 32'd100, 16'h1234, 16'h0001, 16'h0002, 8'd3);
        send_frame(11'd512, 32'd1000, 16'h0010, 16'h0000, 16'h0000, 8'd0);
        send_frame(11'd513, 32'd500, 16'd8000, 16'h0000, 16'h0000, 8'd25);
        send_frame(11'd513, 32'd1000, 16'd100, 16'h0100, 16'hFF00, 8'd26);
        send_frame(11'd513, 32'd1500, 16'd4196, 16'h1234, 16'h4321, 8'd27);
        send_frame(11'd513, 32'd2000, 16'd8293, 16'hFFFE, 16'h0001, 8'd28);
        send_frame(11'd513, 32'd2499, 16'd3, 16'h5555, 16'hAAAA, 8'd29);
        send_frame(11'd513, 32'd2500, 16'd4197, 16'hAAAA, 16'h5555, 8'd30);
        send_frame(11'd513, 32'd3000, 16'd100, 16'h0F0F, 16'hF0F0, 8'd31);
        send_frame(11'd513, 32'hFFFF_FF00, 16'hFFFF, 16'h7FFF, 16'h8000, 8'hFF);
        send_frame(11'd513, 32'h0000_0100, 16'h0000, 16'h8000, 16'h7FFF, 8'h00);
        send_frame(11'd513, 32'h0000_02F0, 16'h0400, 16'h0000, 16'h0000, 8'h01);
        send_frame(11'd513, 32'h0000_0300, 16'h8000, 16'hFFFF, 16'h0000, 8'h80);
        send_frame(11'd513, 32'h0000_0500, 16'h0000, 16'h0000, 16'hFFFF, 8'h7F);
        send_frame(11'h7FF, 32'h0000_0800, 16'h0001, 16'h0001, 16'h0001, 8'h01);
        send_frame(11'h000, 32'h0000_0900, 16'h0002, 16'h0002, 16'h0002, 8'h02);
        drain();

        // Widest id, no rate limit: repeated timestamps pass
        rnd = $urandom;
        write_reg(REG_SPARE_A, rnd[15:0]);
        write_reg(REG_SPARE_B, rnd[31:16]);
        set_config(11'h7FF, 16'd0);
        send_frame(11'h7FF, 32'h0000_0900, 16'h1FFF, 16'hFFFF, 16'hFFFF, 8'h80);
        send_frame(11'h7FF, 32'h0000_0900, 16'h0000, 16'h0000, 16'h0000, 8'h00);
        send_frame(11'h7FE, 32'h0000_0A00, 16'h0100, 16'h0100, 16'h0100, 8'h10);
        drain();

        // Zero id, longest rate limit: a gap of exactly the limit passes, one just after it is dropped
        set_config(11'h000, 16'hFFFF);
        send_frame(11'h000, 32'h0001_0900, 16'd10, 16'h0102, 16'h0304, 8'h05);
        send_frame(11'h000, 32'h0002_08FF, 16'd20, 16'h0607, 16'h0809, 8'h0A);
        send_frame(11'h000, 32'h0002_0900, 16'd30, 16'h0B0C, 16'h0D0E, 8'h0F);
        send_frame(11'h001, 32'h0004_0000, 16'd40, 16'h1011, 16'h1213, 8'h14);

        // Random phases over several setups
        for (ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            drain();
            rnd = $urandom;
            case (ph % 4)
                0: set_config(rnd[10:0], 16'($urandom_range(0, 2000)));
                1: set_config(11'h7FF, 16'hFFFF);
                2: set_config(11'h000, 16'd0);
                default: set_config(rnd[10:0], rnd[31:16]);
            endcase
            if (ph == 2)
                hold_out = 1'b1;
            if (ph == RANDOM_PHASES - 1)
            begin
                gaps_on  = 1'b0;
                stall_on = 1'b0;
            end
            stamp_us   = $urandom;
            walk_angle = int'($urandom_range(0, 8191));
            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                random_frame(used_id);
                if (used_id == cur_id)
                    sent++;
            end
        end
        drain();

        if (mismatches == 0 && outstanding == 0)
            $display("[motor_feedback_multiturn_decoder_top] OK");
        else
            $display("[motor_feedback_multiturn_decoder_top] ERROR");
        $finish;
    end

endmodule
